/* rtl/adpp_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the audio decimator ping-pong block
// no dependencies; imported by every rtl module

package adpp_pkg;

  // ring geometry
  localparam int HALF_SIZE = 32;
  localparam int RING_SIZE = 2 * HALF_SIZE;
  localparam int SLOT_W    = $clog2(RING_SIZE);

  localparam logic [SLOT_W-1:0] HALF_LAST = SLOT_W'(HALF_SIZE - 1);
  localparam logic [SLOT_W-1:0] RING_LAST = SLOT_W'(RING_SIZE - 1);

  // field widths
  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = 16;
  localparam int COUNT_W  = 8;
  localparam int AVG_W    = 8;
  localparam int SLOT_OUT_W = 6;
  localparam int OUT_W    = AVG_W + SLOT_OUT_W + 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hff;

  // divider runs one quotient bit per step
  localparam int DIV_STEPS = AVG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  // item kinds on the input tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic add;      // accumulate the sample of the accepted item
    logic capture;  // snapshot sum and count into the divider, clear them
    logic step;     // one divider iteration
    logic load;     // write the result into the output register
  } adpp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy; // output register holds an item that is not taken this cycle
  } adpp_sts_t;

endpackage

/* rtl/adpp_ctrl.sv */
`timescale 1ns / 1ps
// control state machine for the audio decimator ping-pong block
// depends on adpp_pkg for command and status types

module adpp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_ready,
  input  adpp_pkg::adpp_sts_t sts,
  output adpp_pkg::adpp_cmd_t cmd
);
  import adpp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [STEP_W-1:0]  step, step_next;

  // next state and commands
  always_comb begin
    state_next = state;
    step_next  = '0;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_TICK) begin
            cmd.capture = 1'b1;
            state_next  = ST_DIV;
          end else begin
            cmd.add = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.step  = 1'b1;
        step_next = step + 1'b1;
        if (step == STEP_LAST) begin
          step_next  = '0;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!sts.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

/* rtl/adpp_datapath.sv */
`timescale 1ns / 1ps
// accumulator, ring slot counter, bit-serial divider and output register
// depends on adpp_pkg; driven by adpp_ctrl commands

module adpp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [adpp_pkg::SAMPLE_W-1:0] sample,
  input  adpp_pkg::adpp_cmd_t           cmd,
  output adpp_pkg::adpp_sts_t           sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [adpp_pkg::OUT_W-1:0]    out_data
);
  import adpp_pkg::*;

  logic [SUM_W-1:0]   sample_sum;
  logic [COUNT_W-1:0] sample_count;
  logic [SLOT_W-1:0]  write_slot;

  logic [AVG_W-1:0]   rem;
  logic [AVG_W-1:0]   acc;
  logic [COUNT_W-1:0] divisor;
  logic               div_zero;

  logic [AVG_W:0]     trial;
  logic               trial_ok;
  logic [AVG_W-1:0]   average_byte;
  logic [SLOT_OUT_W-1:0] slot;
  logic               half_ready;
  logic               ready_half;

  // output register is blocked when full and not being taken
  assign sts.out_busy = out_valid && !out_ready;

  // running sum and count, saturating at the count limit
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.capture) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (cmd.add && (sample_count != COUNT_MAX)) begin
      sample_sum   <= sample_sum + SUM_W'(sample);
      sample_count <= sample_count + 1'b1;
    end
  end

  // restoring divider step; the quotient fits eight bits since each sample does
  assign trial    = {rem, acc[AVG_W-1]};
  assign trial_ok = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rem      <= sample_sum[SUM_W-1:AVG_W];
      acc      <= sample_sum[AVG_W-1:0];
      divisor  <= sample_count;
      div_zero <= (sample_count == '0);
    end else if (cmd.step) begin
      rem <= trial_ok ? AVG_W'(trial - {1'b0, divisor}) : trial[AVG_W-1:0];
      acc <= {acc[AVG_W-2:0], trial_ok};
    end
  end

  // result fields
  assign average_byte = div_zero ? '0 : acc;
  assign slot         = SLOT_OUT_W'(write_slot);
  assign half_ready   = (write_slot == HALF_LAST) || (write_slot == RING_LAST);
  assign ready_half   = (write_slot == RING_LAST);

  // ring slot counter advances per result
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (cmd.load) begin
      write_slot <= (write_slot == RING_LAST) ? '0 : write_slot + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= {ready_half, half_ready, slot, average_byte};
    end
  end

endmodule

/* rtl/audio_decimator_ping_pong.sv */
`timescale 1ns / 1ps
// Boxcar-average decimator feeding a two-half ring buffer. A sample item
// (tuser 0) adds to a running sum and count; the count stops at 255 and
// later samples are dropped until the next tick. A tick item (tuser 1)
// snapshots sum and count at the edge that takes it and yields one result
// item: the bit-serial divider produces one quotient bit per cycle, and
// the result is then loaded into the output register once the output side
// is not stalling. The input stays closed until that load. The result
// carries the low byte of the mean (0 for a tick with no samples), the
// ring slot, and a flag naming the half just filled.
// Depends on adpp_pkg, adpp_ctrl and adpp_datapath.

module audio_decimator_ping_pong (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [adpp_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [7:0] sample
  input  logic                          s_axis_tuser,  // [0] kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] average_byte, [13:8] slot, [14] half_ready, [15] ready_half
  output logic [adpp_pkg::OUT_W-1:0]    m_axis_tdata
);
  import adpp_pkg::*;

  adpp_cmd_t cmd;
  adpp_sts_t sts;

  // control
  adpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  adpp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .sample    (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

/* rtl/adpp_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the audio decimator ping-pong block
// depends on adpp_pkg; bound to audio_decimator_ping_pong below

module adpp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [adpp_pkg::OUT_W-1:0]    m_axis_tdata
);
  import adpp_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed");

  // ready half is only named when a half completed
  a_half_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_W-2] || !m_axis_tdata[OUT_W-1]))
    else $error("ready_half set without half_ready");

  // a tick keeps the input closed while the divider runs
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_TICK) |=> !s_axis_tready)
    else $error("input open right after a tick item");

  // a sample item never opens a result by itself
  a_sample_quiet: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_SAMPLE)
    |=> !m_axis_tvalid)
    else $error("result item after a sample item");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind audio_decimator_ping_pong adpp_checker u_adpp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
